[hw/rtl/rlpb_pkg.sv]
// Shared types and constants for the RGB LED PWM blinker.
// Used by rlpb_led_step and rgb_led_pwm_blinker; no dependencies.
package rlpb_pkg;

  localparam int unsigned NumLeds = 8;
  localparam int unsigned LedIdxW = (NumLeds > 1) ? $clog2(NumLeds) : 1;
  localparam int unsigned LedCntW = $clog2(NumLeds + 1);

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdColor = 2'd1,
    CmdBlink = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegActiveLow = 2'd0,
    RegPrescale  = 2'd1,
    RegLedsInUse = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFinish
  } state_e;

  // Per-LED state record; duty is {blue, green, red}
  typedef struct packed {
    logic [23:0] duty;
    logic [7:0]  phase;
    logic        blink;
    logic        lit;
    logic [15:0] on_len;
    logic [15:0] off_len;
    logic [15:0] countdown;
  } led_state_t;

endpackage

[hw/rtl/rlpb_led_step.sv]
// One LED's PWM compare and blink timer update for a tick.
// Shared by all LEDs under the top-level sequencer; uses rlpb_pkg.
module rlpb_led_step (
  input  rlpb_pkg::led_state_t st_i,
  input  logic                 ms_tick_i,
  output rlpb_pkg::led_state_t st_o,
  output logic [2:0]           bits_o
);

  logic       show;
  logic [2:0] pwm_bits;

  assign show = !st_i.blink || st_i.lit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pwm_bits[c] = (st_i.duty[8*c +: 8] != 8'd0) && (st_i.duty[8*c +: 8] >= st_i.phase) && show;
    end
  end

  always_comb begin
    st_o       = st_i;
    st_o.phase = st_i.phase + 8'd1;
    bits_o     = pwm_bits;
    if (ms_tick_i && st_i.blink) begin
      if (st_i.countdown != 16'd0) begin
        st_o.countdown = st_i.countdown - 16'd1;
      end else if (st_i.lit) begin
        // going dark forces the pins off right away
        st_o.countdown = st_i.off_len;
        st_o.lit       = 1'b0;
        bits_o         = 3'b000;
      end else begin
        st_o.countdown = st_i.on_len;
        st_o.lit       = 1'b1;
        st_o.phase     = 8'd0;
      end
    end
  end

endmodule

[hw/rtl/rgb_led_pwm_blinker.sv]
// RGB LED PWM blinker top level: stream ports, config registers, LED sequencer.
// Uses rlpb_pkg and rlpb_led_step.
// A tick item walks the n = min(leds_in_use, NumLeds) active LEDs in state StWalk,
// one LED per cycle through the shared step unit, then loads its result into the
// output register in StFinish; other commands go straight to StFinish. StFinish waits
// while a result is held and m_axis_tready is low; the next item is taken while a
// result waits in the output register. Reset clears all LED state, pins dark,
// prescale_limit = 48, active_low = 0, leds_in_use = 0.
module rgb_led_pwm_blinker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: led_index[2:0], red[10:3], green[18:11], blue[26:19],
  //        time_on[42:27], off_time[58:43], zero fill [63:59]
  input  logic [63:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: led_pins[23:0], lit_phases[31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = rlpb_pkg::LedIdxW;
  localparam int unsigned CntW = rlpb_pkg::LedCntW;
  localparam int unsigned PinW = 3 * rlpb_pkg::NumLeds;

  rlpb_pkg::state_e state_q, state_d;

  logic        active_low_q;
  logic [15:0] prescale_limit_q;
  logic [3:0]  leds_in_use_q;
  logic [15:0] prescaler_q;
  logic        ms_tick_q;
  logic [IdxW-1:0] cnt_q;

  rlpb_pkg::led_state_t led_q [rlpb_pkg::NumLeds];
  logic [2:0]           pin_q [rlpb_pkg::NumLeds];

  logic        out_valid_q;
  logic [31:0] out_data_q;

  // payload fields
  rlpb_pkg::cmd_e  cmd;
  logic [IdxW-1:0] idx;
  logic [2:0]      idx_raw;
  logic [23:0]     color;
  logic [15:0]     t_on, t_off;

  logic            accept;
  logic            in_range;
  logic [CntW-1:0] n_act;
  logic            walk_last;
  logic            load_out;
  logic            walk_en;

  rlpb_pkg::led_state_t step_in, step_out;
  logic [2:0]           step_bits;

  logic [PinW-1:0] pins_flat;
  logic [23:0]     pins_out;
  logic [7:0]      lits;

  assign cmd     = rlpb_pkg::cmd_e'(s_axis_tuser);
  assign idx_raw = s_axis_tdata[2:0];
  assign idx     = IdxW'(idx_raw);
  assign color   = {s_axis_tdata[26:19], s_axis_tdata[18:11], s_axis_tdata[10:3]};
  assign t_on    = s_axis_tdata[42:27];
  assign t_off   = s_axis_tdata[58:43];

  assign in_range = 32'(idx_raw) < rlpb_pkg::NumLeds;
  assign n_act    = (32'(leds_in_use_q) > rlpb_pkg::NumLeds) ?
                    CntW'(rlpb_pkg::NumLeds) : CntW'(leds_in_use_q);
  assign walk_last = CntW'(cnt_q) == (n_act - CntW'(1));

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlpb_pkg::StIdle: begin
        if (accept) begin
          if (cmd == rlpb_pkg::CmdTick && n_act != CntW'(0)) begin
            state_d = rlpb_pkg::StWalk;
          end else begin
            state_d = rlpb_pkg::StFinish;
          end
        end
      end
      rlpb_pkg::StWalk: begin
        if (walk_last) begin
          state_d = rlpb_pkg::StFinish;
        end
      end
      rlpb_pkg::StFinish: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = rlpb_pkg::StIdle;
        end
      end
      default: state_d = rlpb_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    walk_en       = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      rlpb_pkg::StIdle:   s_axis_tready = 1'b1;
      rlpb_pkg::StWalk:   walk_en = 1'b1;
      rlpb_pkg::StFinish: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign step_in = led_q[cnt_q];

  rlpb_led_step u_step (
    .st_i      (step_in),
    .ms_tick_i (ms_tick_q),
    .st_o      (step_out),
    .bits_o    (step_bits)
  );

  always_comb begin
    for (int i = 0; i < rlpb_pkg::NumLeds; i++) begin
      pins_flat[3*i +: 3] = pin_q[i];
    end
    lits = 8'd0;
    for (int i = 0; i < rlpb_pkg::NumLeds && i < 8; i++) begin
      lits[i] = led_q[i].lit;
    end
  end

  assign pins_out = 24'(pins_flat) ^ {24{active_low_q}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlpb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q     <= 1'b0;
      prescale_limit_q <= 16'd48;
      leds_in_use_q    <= 4'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rlpb_pkg::reg_e'(cfg_addr_i))
        rlpb_pkg::RegActiveLow: active_low_q     <= cfg_data_i[0];
        rlpb_pkg::RegPrescale:  prescale_limit_q <= cfg_data_i;
        rlpb_pkg::RegLedsInUse: leds_in_use_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer counter and prescaler
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q <= 16'd0;
      ms_tick_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept && cmd == rlpb_pkg::CmdTick) begin
        ms_tick_q   <= prescaler_q >= prescale_limit_q;
        prescaler_q <= (prescaler_q >= prescale_limit_q) ? 16'd0 : prescaler_q + 16'd1;
        cnt_q       <= '0;
      end else if (walk_en) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // LED state and pin levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rlpb_pkg::NumLeds; i++) begin
        led_q[i] <= '0;
        pin_q[i] <= 3'b000;
      end
    end else if (walk_en) begin
      led_q[cnt_q] <= step_out;
      pin_q[cnt_q] <= step_bits;
    end else if (accept && in_range) begin
      case (cmd)
        rlpb_pkg::CmdColor: led_q[idx].duty <= color;
        rlpb_pkg::CmdBlink: begin
          led_q[idx].blink     <= 1'b0;
          led_q[idx].on_len    <= t_on;
          led_q[idx].off_len   <= t_off;
          led_q[idx].countdown <= t_on;
          if (CntW'(idx) < n_act) begin
            if (t_on != 16'd0) begin
              led_q[idx].phase <= 8'd0;
              led_q[idx].lit   <= 1'b1;
              led_q[idx].blink <= t_off != 16'd0;
            end else begin
              led_q[idx].duty <= 24'd0;
              led_q[idx].lit  <= 1'b0;
            end
          end
        end
        rlpb_pkg::CmdClear: begin
          led_q[idx] <= '0;
          pin_q[idx] <= 3'b000;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {lits, pins_out};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
